FILE: hw/rtl/dldw_pkg.sv
// Shared types and line-state codes for the DSI low-power DCS write transmitter.
package dldw_pkg;

  localparam int JOB_BYTES = 5;

  localparam logic [1:0] LS_00 = 2'b00;
  localparam logic [1:0] LS_01 = 2'b01;
  localparam logic [1:0] LS_10 = 2'b10;
  localparam logic [1:0] LS_11 = 2'b11;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        is_command;
    logic [15:0] param_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0] first_state;
    logic [1:0] second_state;
    logic       has_second;
    logic       end_of_run;
  } out_item_t;

  // One queued transmit job: what a single accepted item puts on the lane.
  typedef struct packed {
    logic                           exit_pre;
    logic                           entry;
    logic [2:0]                     nbytes;
    logic [JOB_BYTES-1:0][7:0]      bytes;
    logic                           exit_post;
  } job_t;

endpackage

FILE: hw/rtl/dldw_front.sv
// Front end: accepts items, tracks the open write and builds transmit jobs.
module dldw_front import dldw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     job_valid,
  input  logic     job_ready,
  output job_t     job
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SHORT = 2'd1;
  localparam logic [1:0] PH_LCMD  = 2'd2;
  localparam logic [1:0] PH_LPAR  = 2'd3;

  localparam logic [7:0]  LPDT_CODE = 8'h87;
  localparam logic [7:0]  DI_SHORT0 = 8'h05;
  localparam logic [7:0]  DI_SHORT1 = 8'h15;
  localparam logic [7:0]  DI_LONG   = 8'h39;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_INIT  = 16'hffff;
  localparam logic [15:0] CNT_MAX   = 16'hfffe;

  localparam logic [23:0] ECC_MASK [6] = '{
    24'hF12CB7, 24'hF2555B, 24'h749A6D, 24'hB8E38E, 24'hDF03F0, 24'hEFFC00
  };

  function automatic logic [7:0] header_ecc(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    logic [23:0] v;
    logic [7:0]  e;
    v = {b2, b1, b0};
    e = '0;
    for (int i = 0; i < 6; i++) begin
      e[i] = ^(v & ECC_MASK[i]);
    end
    return e;
  endfunction

  function automatic logic [15:0] crc_byte(logic [15:0] c_in, logic [7:0] v);
    logic [15:0] c;
    c = c_in;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ v[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  logic [1:0]  phase, phase_next;
  logic [15:0] params_left, params_left_next;
  // In a long write this already includes the command byte, which is sent later.
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  held_command;

  logic [15:0] cnt;
  logic [15:0] wc;
  logic [15:0] crc_upd;
  logic [15:0] left_dec;
  logic        accept;
  job_t        job_c;
  logic        job_any;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cnt      = (in_item.param_count > CNT_MAX) ? CNT_MAX : in_item.param_count;
    wc       = cnt + 16'd1;
    crc_upd  = crc_byte(running_crc, in_item.data_byte);
    left_dec = (params_left != '0) ? params_left - 16'd1 : '0;

    phase_next       = phase;
    params_left_next = params_left;
    running_crc_next = running_crc;
    job_c            = '0;
    job_any          = 1'b0;

    if (in_item.is_command) begin
      job_c.exit_pre = (phase == PH_LCMD) || (phase == PH_LPAR);
      job_any        = job_c.exit_pre;
      if (cnt == '0) begin
        job_c.entry     = 1'b1;
        job_c.nbytes    = 3'd5;
        job_c.bytes[0]  = LPDT_CODE;
        job_c.bytes[1]  = DI_SHORT0;
        job_c.bytes[2]  = in_item.data_byte;
        job_c.bytes[3]  = 8'h00;
        job_c.bytes[4]  = header_ecc(DI_SHORT0, in_item.data_byte, 8'h00);
        job_c.exit_post = 1'b1;
        job_any         = 1'b1;
        phase_next       = PH_IDLE;
        params_left_next = '0;
        running_crc_next = CRC_INIT;
      end else if (cnt == 16'd1) begin
        phase_next       = PH_SHORT;
        params_left_next = 16'd1;
        running_crc_next = CRC_INIT;
      end else begin
        job_c.entry    = 1'b1;
        job_c.nbytes   = 3'd5;
        job_c.bytes[0] = LPDT_CODE;
        job_c.bytes[1] = DI_LONG;
        job_c.bytes[2] = wc[7:0];
        job_c.bytes[3] = wc[15:8];
        job_c.bytes[4] = header_ecc(DI_LONG, wc[7:0], wc[15:8]);
        job_any        = 1'b1;
        phase_next       = PH_LCMD;
        params_left_next = cnt;
        running_crc_next = crc_byte(CRC_INIT, in_item.data_byte);
      end
    end else begin
      case (phase)
        PH_SHORT: begin
          job_c.entry     = 1'b1;
          job_c.nbytes    = 3'd5;
          job_c.bytes[0]  = LPDT_CODE;
          job_c.bytes[1]  = DI_SHORT1;
          job_c.bytes[2]  = held_command;
          job_c.bytes[3]  = in_item.data_byte;
          job_c.bytes[4]  = header_ecc(DI_SHORT1, held_command, in_item.data_byte);
          job_c.exit_post = 1'b1;
          job_any         = 1'b1;
          phase_next       = PH_IDLE;
          params_left_next = '0;
        end
        PH_LCMD, PH_LPAR: begin
          job_any          = 1'b1;
          params_left_next = left_dec;
          if (phase == PH_LCMD) begin
            job_c.bytes[0] = held_command;
            job_c.bytes[1] = in_item.data_byte;
            job_c.bytes[2] = crc_upd[7:0];
            job_c.bytes[3] = crc_upd[15:8];
            job_c.nbytes   = (left_dec == '0) ? 3'd4 : 3'd2;
          end else begin
            job_c.bytes[0] = in_item.data_byte;
            job_c.bytes[1] = crc_upd[7:0];
            job_c.bytes[2] = crc_upd[15:8];
            job_c.nbytes   = (left_dec == '0) ? 3'd3 : 3'd1;
          end
          if (left_dec == '0) begin
            job_c.exit_post  = 1'b1;
            phase_next       = PH_IDLE;
            running_crc_next = CRC_INIT;
          end else begin
            phase_next       = PH_LPAR;
            running_crc_next = crc_upd;
          end
        end
        default: begin
          // A parameter with no open write is dropped.
          job_any = 1'b0;
        end
      endcase
    end
  end

  assign job_valid = in_valid && job_any;
  assign job       = job_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      params_left <= '0;
      running_crc <= CRC_INIT;
    end else if (accept) begin
      phase       <= phase_next;
      params_left <= params_left_next;
      running_crc <= running_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_item.is_command) begin
      held_command <= in_item.data_byte;
    end
  end

endmodule

FILE: hw/rtl/dldw_fifo.sv
// Short job queue between the front end and the slot serializer.
module dldw_fifo import dldw_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/dldw_back.sv
// Slot serializer: turns queued jobs into one line-state slot per cycle while the output is not stalled.
module dldw_back import dldw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job_in,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam logic [2:0] SEG_PRE   = 3'd0;
  localparam logic [2:0] SEG_ENTRY = 3'd1;
  localparam logic [2:0] SEG_BYTES = 3'd2;
  localparam logic [2:0] SEG_POST  = 3'd3;
  localparam logic [2:0] SEG_DONE  = 3'd4;

  // First segment at or after start that the job actually contains.
  function automatic logic [2:0] seg_from(job_t j, logic [2:0] start);
    logic [2:0] s;
    s = SEG_DONE;
    if (start <= SEG_POST && j.exit_post) s = SEG_POST;
    if (start <= SEG_BYTES && j.nbytes != '0) s = SEG_BYTES;
    if (start <= SEG_ENTRY && j.entry) s = SEG_ENTRY;
    if (start <= SEG_PRE && j.exit_pre) s = SEG_PRE;
    return s;
  endfunction

  job_t       job;
  logic       busy;
  logic [2:0] seg;
  logic [2:0] sub;
  logic [2:0] bidx;

  logic       out_adv;
  logic       seg_last;
  logic [2:0] seg_nxt;
  logic       job_last;
  logic       load;
  out_item_t  slot;
  logic [7:0] cur_byte;

  assign out_adv = !out_valid || out_ready;

  always_comb begin
    cur_byte = job.bytes[bidx];
    slot     = '0;
    seg_last = 1'b0;
    case (seg)
      SEG_PRE, SEG_POST: begin
        seg_last = (sub == 3'd1);
        if (sub == 3'd0) begin
          slot.first_state  = LS_00;
          slot.second_state = LS_10;
          slot.has_second   = 1'b1;
        end else begin
          slot.first_state  = LS_11;
          slot.second_state = LS_00;
          slot.has_second   = 1'b0;
        end
      end
      SEG_ENTRY: begin
        seg_last          = (sub == 3'd1);
        slot.first_state  = (sub == 3'd0) ? LS_10 : LS_01;
        slot.second_state = LS_00;
        slot.has_second   = 1'b1;
      end
      SEG_BYTES: begin
        seg_last          = (sub == 3'd7) && (bidx == job.nbytes - 3'd1);
        slot.first_state  = cur_byte[sub] ? LS_10 : LS_01;
        slot.second_state = LS_00;
        slot.has_second   = 1'b1;
      end
      default: begin
        seg_last = 1'b1;
      end
    endcase
    seg_nxt         = seg_from(job, seg + 3'd1);
    job_last        = seg_last && (seg_nxt == SEG_DONE);
    slot.end_of_run = job_last;
  end

  // A new job loads in the cycle the previous one gives its last slot.
  assign load      = job_valid && (!busy || (out_adv && job_last));
  assign job_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      seg       <= SEG_DONE;
      sub       <= '0;
      bidx      <= '0;
    end else begin
      if (out_adv) begin
        out_valid <= busy;
      end
      if (load) begin
        busy <= 1'b1;
        seg  <= seg_from(job_in, SEG_PRE);
        sub  <= '0;
        bidx <= '0;
      end else if (out_adv && busy) begin
        if (job_last) begin
          busy <= 1'b0;
        end else if (seg_last) begin
          seg  <= seg_nxt;
          sub  <= '0;
          bidx <= '0;
        end else if (seg == SEG_BYTES && sub == 3'd7) begin
          sub  <= '0;
          bidx <= bidx + 3'd1;
        end else begin
          sub <= sub + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= job_in;
    end
    if (out_adv && busy) begin
      out_item <= slot;
    end
  end

endmodule

FILE: hw/rtl/dsi_lp_dcs_write_transmitter.sv
// Top level of the DSI data-lane-0 low-power DCS write transmitter.
// A DCS write enters as a command item (command byte plus parameter count) followed by
// its parameter items; the block emits one result per bit slot of the lane: escape
// entry, the LPDT code, the packet bytes LSB first and the exit sequence. No parameter
// gives short packet 0x05, one gives 0x15, more give long packet 0x39 with a CRC-16.
// Parameter items with no open write are dropped; a command during an open long write
// closes its escape first. The front end takes an item whenever its job
// queue (QUEUE_DEPTH entries) has room; the serializer behind it gives one slot per
// cycle while the output is not stalled, so an item costs as many cycles as the slots
// it causes, and a command that closes an open long write adds the exit slots. Jobs
// follow each other with no gap.
module dsi_lp_dcs_write_transmitter import dldw_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic q_push_valid, q_push_ready;
  logic q_pop_valid, q_pop_ready;
  job_t q_push_job, q_pop_job;

  dldw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .job_valid (q_push_valid),
    .job_ready (q_push_ready),
    .job       (q_push_job)
  );

  dldw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_job   (q_push_job),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_job    (q_pop_job)
  );

  dldw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_pop_valid),
    .job_ready (q_pop_ready),
    .job_in    (q_pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

FILE: tb/sv/dsi_lp_dcs_write_transmitter_test.sv
// Self-checking testbench for the DSI low-power DCS write transmitter, with its lane predictor.
package lane_check_pkg;
  import dldw_pkg::*;

  typedef enum logic [1:0] {
    WR_IDLE, WR_SHORT_WAIT, WR_LONG_HEAD, WR_LONG_BODY
  } write_phase_e;

  localparam logic [7:0]  DT_SHORT_NO_PARAM  = 8'h05;
  localparam logic [7:0]  DT_SHORT_ONE_PARAM = 8'h15;
  localparam logic [7:0]  DT_LONG_WRITE      = 8'h39;
  localparam logic [7:0]  LPDT_ESCAPE        = 8'h87;
  localparam logic [15:0] CRC_POLY           = 16'h8408;
  localparam logic [15:0] CRC_SEED           = 16'hFFFF;
  localparam logic [15:0] MAX_PARAM_COUNT    = 16'd65534;
  localparam int          MAX_PRINTED        = 20;

  // Parity masks of the six header ECC bits, bit 0 in the lowest entry.
  localparam logic [5:0][23:0] ECC_MASKS = {
    24'hEFFC00, 24'hDF03F0, 24'hB8E38E, 24'h749A6D, 24'hF2555B, 24'hF12CB7
  };

  class lp_lane_model;
    write_phase_e phase;
    logic [15:0]  params_left;
    logic [15:0]  crc;
    logic [7:0]   held_cmd;
    out_item_t    pending_slots[$];
    out_item_t    step_slots[$];
    int           mismatches;
    int           items_taken;
    int           slots_seen;

    function new();
      phase       = WR_IDLE;
      params_left = '0;
      crc         = CRC_SEED;
      held_cmd    = '0;
      mismatches  = 0;
      items_taken = 0;
      slots_seen  = 0;
    endfunction

    function void add_slot(logic [1:0] st_a, logic [1:0] st_b, logic two);
      out_item_t s;
      s.first_state  = st_a;
      s.second_state = two ? st_b : LS_00;
      s.has_second   = two;
      s.end_of_run   = 1'b0;
      step_slots.push_back(s);
    endfunction

    function void add_byte(logic [7:0] b);
      for (int i = 0; i < 8; i++) add_slot(b[i] ? LS_10 : LS_01, LS_00, 1'b1);
    endfunction

    function void add_entry();
      add_slot(LS_10, LS_00, 1'b1);
      add_slot(LS_01, LS_00, 1'b1);
      add_byte(LPDT_ESCAPE);
    endfunction

    function void add_exit();
      add_slot(LS_00, LS_10, 1'b1);
      add_slot(LS_11, LS_00, 1'b0);
    endfunction

    function logic [5:0] header_ecc(logic [23:0] hdr);
      logic [5:0] e;
      for (int i = 0; i < 6; i++) e[i] = ^(hdr & ECC_MASKS[i]);
      return e;
    endfunction

    function void crc_update(logic [7:0] b);
      for (int i = 0; i < 8; i++) begin
        if (crc[0] ^ b[i]) crc = (crc >> 1) ^ CRC_POLY;
        else crc = crc >> 1;
      end
    endfunction

    function void add_header(logic [7:0] di, logic [7:0] b1, logic [7:0] b2);
      add_byte(di);
      add_byte(b1);
      add_byte(b2);
      add_byte({2'b00, header_ecc({b2, b1, di})});
    endfunction

    function void short_packet(logic [7:0] di, logic [7:0] b1, logic [7:0] b2);
      add_entry();
      add_header(di, b1, b2);
      add_exit();
    endfunction

    // Works out every slot that one accepted item puts on the lane.
    function void take_item(in_item_t it);
      logic [15:0] cnt;
      logic [15:0] wc;
      out_item_t   s;
      step_slots.delete();
      items_taken++;
      cnt = (it.param_count > MAX_PARAM_COUNT) ? MAX_PARAM_COUNT : it.param_count;
      if (it.is_command) begin
        // A long write that is still open has its escape closed first.
        if (phase == WR_LONG_HEAD || phase == WR_LONG_BODY) add_exit();
        held_cmd = it.data_byte;
        crc      = CRC_SEED;
        if (cnt == 16'd0) begin
          short_packet(DT_SHORT_NO_PARAM, it.data_byte, 8'h00);
          phase       = WR_IDLE;
          params_left = '0;
        end else if (cnt == 16'd1) begin
          phase       = WR_SHORT_WAIT;
          params_left = 16'd1;
        end else begin
          wc          = cnt + 16'd1;
          phase       = WR_LONG_HEAD;
          params_left = cnt;
          add_entry();
          add_header(DT_LONG_WRITE, wc[7:0], wc[15:8]);
        end
      end else begin
        case (phase)
          WR_SHORT_WAIT: begin
            short_packet(DT_SHORT_ONE_PARAM, held_cmd, it.data_byte);
            phase       = WR_IDLE;
            params_left = '0;
          end
          WR_LONG_HEAD, WR_LONG_BODY: begin
            if (phase == WR_LONG_HEAD) begin
              add_byte(held_cmd);
              crc_update(held_cmd);
              phase = WR_LONG_BODY;
            end
            add_byte(it.data_byte);
            crc_update(it.data_byte);
            if (params_left != 16'd0) params_left = params_left - 16'd1;
            if (params_left == 16'd0) begin
              add_byte(crc[7:0]);
              add_byte(crc[15:8]);
              add_exit();
              phase = WR_IDLE;
              crc   = CRC_SEED;
            end
          end
          default: ;
        endcase
      end
      if (step_slots.size() > 0) begin
        s            = step_slots[step_slots.size() - 1];
        s.end_of_run = 1'b1;
        step_slots[step_slots.size() - 1] = s;
      end
      foreach (step_slots[i]) pending_slots.push_back(step_slots[i]);
    endfunction

    task report_mismatch(string what, logic [15:0] got_v, logic [15:0] want_v);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
        $display("MISMATCH at slot %0d, %s: got %0h, expected %0h", slots_seen, what,
                 got_v, want_v);
    endtask

    task check_slot(out_item_t got);
      out_item_t want;
      slots_seen++;
      if (pending_slots.size() == 0) begin
        report_mismatch("slot with no item behind it", 16'(got), '0);
        return;
      end
      want = pending_slots.pop_front();
      if (got.first_state !== want.first_state)
        report_mismatch("first_state", 16'(got.first_state), 16'(want.first_state));
      if (got.second_state !== want.second_state)
        report_mismatch("second_state", 16'(got.second_state), 16'(want.second_state));
      if (got.has_second !== want.has_second)
        report_mismatch("has_second", 16'(got.has_second), 16'(want.has_second));
      if (got.end_of_run !== want.end_of_run)
        report_mismatch("end_of_run", 16'(got.end_of_run), 16'(want.end_of_run));
    endtask
  endclass

endpackage

module dsi_lp_dcs_write_transmitter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dldw_pkg::*;
  import lane_check_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 60;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_req      = 1'b0;
  int   hold_left     = 0;

  lp_lane_model lane = new();

  dsi_lp_dcs_write_transmitter DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver side: checks each accepted slot and decides the next ready.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) lane.check_slot(out_item);
      if (hold_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Valid stays up from one item to the next unless a gap is drawn.
  task automatic offer(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lane.take_item(it);
  endtask

  task automatic send_cmd(input logic [7:0] cmd, input logic [15:0] count);
    in_item_t it;
    it.data_byte   = cmd;
    it.is_command  = 1'b1;
    it.param_count = count;
    offer(it);
  endtask

  task automatic send_param(input logic [7:0] b);
    in_item_t it;
    it.data_byte   = b;
    it.is_command  = 1'b0;
    it.param_count = 16'($urandom_range(65535));
    offer(it);
  endtask

  task automatic send_write(input logic [7:0] cmd, input int n);
    send_cmd(cmd, 16'(n));
    repeat (n) send_param(8'($urandom_range(255)));
  endtask

  // Mostly complete writes of small size, with some cut-short writes carrying
  // arbitrary counts and a few stray parameters in between.
  task automatic random_traffic(input int target);
    int done_items;
    int pick;
    int n;
    done_items = 0;
    while (done_items < target) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_param(8'($urandom_range(255)));
      end else if (pick < 14) begin
        n = $urandom_range(3);
        send_cmd(8'($urandom_range(255)), 16'($urandom_range(65535)));
        repeat (n) send_param(8'($urandom_range(255)));
        done_items += n + 1;
      end else begin
        n = ($urandom_range(99) < 75) ? $urandom_range(4) : $urandom_range(24, 5);
        send_write(8'($urandom_range(255)), n);
        done_items += n + 1;
      end
    end
  endtask

  initial begin
    send_idle_pct = 34;
    recv_idle_pct = 68;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_param(8'h5A);
    send_cmd(8'h00, 16'd0);
    send_cmd(8'hFF, 16'd1);
    send_param(8'hFF);
    send_cmd(8'h2C, 16'd2);
    send_param(8'h00);
    send_param(8'hFF);
    // An all-ones count saturates; the write is then cut short mid-body.
    send_cmd(8'h3C, 16'hFFFF);
    send_param(8'hA5);
    send_cmd(8'h11, 16'd0);
    send_cmd(8'h51, 16'd1);
    send_cmd(8'h2A, 16'd3);
    send_param(8'h00);
    send_param(8'h12);
    send_param(8'hFF);
    // A long write abandoned before its command byte went out.
    send_cmd(8'h80, 16'd65534);
    send_cmd(8'h29, 16'd0);
    send_param(8'hFF);

    random_traffic(45);
    send_idle_pct = 68;
    recv_idle_pct = 34;
    random_traffic(45);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    random_traffic(50);
    in_valid <= 1'b0;

    while (lane.pending_slots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (short, long, cut-short writes, stray parameters);",
             lane.items_taken);
    $display("checked %0d slots under random stalls and one long output hold-off.",
             lane.slots_seen);
    if (lane.mismatches == 0) begin
      $display("dsi_lp_dcs_write_transmitter_test OK");
    end else begin
      $display("dsi_lp_dcs_write_transmitter_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d slots still expected.", lane.pending_slots.size());
    $display("dsi_lp_dcs_write_transmitter_test NOT OK");
    $finish;
  end

endmodule
